@@ rtl/core/sgb_pkg.sv @@
// Shared types, codes and widths of the separable Gaussian blur block.
// No dependencies; every other file of the block imports this package.
package sgb_pkg;

	localparam int DEF_MAX_ROWS = 256;
	localparam int DEF_MAX_COLS = 256;

	localparam int NTAPS     = 9;
	localparam int CENTER    = 4;
	localparam int PIX_W     = 8;
	localparam int SAMPLE_W  = 16;
	localparam int WEIGHT_W  = 16;
	localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
	localparam int WSUM_W    = 20;
	localparam int DIVISOR_W = WSUM_W + 8;
	localparam int QUOT_W    = 16;
	localparam int REM_W     = DIVISOR_W + QUOT_W;
	localparam int TOTAL_W   = 36;
	localparam int DIM_W     = 9;
	localparam int HW_W      = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_RUN   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS   = 3'd0,
		REG_COLS   = 3'd1,
		REG_HALF   = 3'd2,
		REG_TAP0   = 3'd3,
		REG_TAP1   = 3'd4,
		REG_TAP2   = 3'd5,
		REG_TAP3   = 3'd6,
		REG_TAP4   = 3'd7
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PASS1 = 5'b00010,
		ST_PASS2 = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_CLEAR = 5'b10000
	} state_t;

endpackage

@@ rtl/core/sgb_tap_cell.sv @@
// One cell of the tap line: holds a sample, hands it to its neighbor every cycle
// and registers the sample times its weight. Depends on sgb_pkg.
module sgb_tap_cell
	import sgb_pkg::*;
(
	input  logic                clk,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic [WEIGHT_W-1:0] weight,
	output logic [SAMPLE_W-1:0] sample_q,
	output logic [PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		sample_q <= sample_in;
		prod_q   <= sample_q * weight;
	end

endmodule

@@ rtl/core/sgb_div_cell.sv @@
// One cell of the divider line: decides one quotient bit by compare and subtract
// and passes the remainder on. Depends on sgb_pkg.
module sgb_div_cell
	import sgb_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic                 clk,
	input  logic [REM_W-1:0]     rem_in,
	input  logic [QUOT_W-1:0]    quot_in,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic [REM_W-1:0]     rem_q,
	output logic [QUOT_W-1:0]    quot_q
);

	logic [REM_W-1:0] shifted;

	assign shifted = REM_W'(divisor) << SHIFT;

	always_ff @(posedge clk) begin
		if (rem_in >= shifted) begin
			rem_q  <= rem_in - shifted;
			quot_q <= quot_in | (QUOT_W'(1) << SHIFT);
		end else begin
			rem_q  <= rem_in;
			quot_q <= quot_in;
		end
	end

endmodule

@@ rtl/core/separable_gaussian_blur.sv @@
// Separable Gaussian blur over a stored grayscale frame.
// Slave channel requests: tuser holds the kind (write, run, read, unused);
// tdata holds row [7:0], col [15:8], pixel [23:16]. A write stores one pixel
// and a read returns one result on the master channel: tdata is the pixel
// value, tuser the zero-weight flag of the last run. A read fetches the pixel
// into a read register, then into the master output register once it is free.
// A run blurs the active frame in place. The first pass walks each column,
// the second each row, streaming clamped samples through a line of nine tap
// cells, a two-level adder tree and a sixteen-cell divider line, one pixel
// per cycle. With a zero tap sum a run instead clears the active frame.
// The slave channel is not ready during a run, nor while a read result waits
// behind a stalled master channel with another read already fetched.
// Reset clears control state and restores the default registers; the pixel
// stores are undefined until written.
module separable_gaussian_blur
	import sgb_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // row, col, pixel
	input  logic [1:0]           s_tuser,   // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // value
	output logic                 m_tuser,   // zero_weight
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MAXD   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int LINE_W = $clog2(MAXD + 9);
	localparam int TAG_N  = 22;

	function automatic logic [AW-1:0] addr_of(input logic [LINE_W-1:0] r,
		input logic [LINE_W-1:0] c);
		return AW'(r) * AW'(MAX_COLS) + AW'(c);
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0]    rows_cfg_q, cols_cfg_q;
	logic [HW_W-1:0]     half_q;
	logic [WEIGHT_W-1:0] tap_q [5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= DIM_W'(256);
			cols_cfg_q <= DIM_W'(256);
			half_q     <= HW_W'(4);
			tap_q[0]   <= WEIGHT_W'(26145);
			tap_q[1]   <= WEIGHT_W'(15857);
			tap_q[2]   <= WEIGHT_W'(3539);
			tap_q[3]   <= WEIGHT_W'(290);
			tap_q[4]   <= WEIGHT_W'(9);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_ROWS: rows_cfg_q <= cfg_data[DIM_W-1:0];
				REG_COLS: cols_cfg_q <= cfg_data[DIM_W-1:0];
				REG_HALF: half_q     <= cfg_data[HW_W-1:0];
				REG_TAP0: tap_q[0]   <= cfg_data;
				REG_TAP1: tap_q[1]   <= cfg_data;
				REG_TAP2: tap_q[2]   <= cfg_data;
				REG_TAP3: tap_q[3]   <= cfg_data;
				REG_TAP4: tap_q[4]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derived run settings; the user must keep registers stable for the whole run (not enforced).
	logic [LINE_W-1:0]   rows_eff, cols_eff;
	logic [HW_W-1:0]     hw_eff;
	logic [WSUM_W-1:0]   wsum;
	logic [WEIGHT_W-1:0] weight [NTAPS];

	always_comb begin
		if (rows_cfg_q == '0) rows_eff = LINE_W'(1);
		else if (32'(rows_cfg_q) > MAX_ROWS) rows_eff = LINE_W'(MAX_ROWS);
		else rows_eff = LINE_W'(rows_cfg_q);
		if (cols_cfg_q == '0) cols_eff = LINE_W'(1);
		else if (32'(cols_cfg_q) > MAX_COLS) cols_eff = LINE_W'(MAX_COLS);
		else cols_eff = LINE_W'(cols_cfg_q);
		hw_eff = (half_q > HW_W'(4)) ? HW_W'(4) : half_q;
		wsum = WSUM_W'(tap_q[0]);
		for (int d = 1; d < 5; d++) begin
			if (HW_W'(d) <= hw_eff) wsum = wsum + WSUM_W'({tap_q[d], 1'b0});
		end
		for (int j = 0; j < NTAPS; j++) begin
			if (HW_W'(j > CENTER ? j - CENTER : CENTER - j) <= hw_eff)
				weight[j] = tap_q[j > CENTER ? j - CENTER : CENTER - j];
			else
				weight[j] = '0;
		end
	end

	// Request decode.
	kind_t         in_kind;
	logic [7:0]    in_row, in_col, in_pix;
	logic          in_range, accept;
	logic [AW-1:0] in_addr;

	assign in_kind  = kind_t'(s_tuser);
	assign in_row   = s_tdata[7:0];
	assign in_col   = s_tdata[15:8];
	assign in_pix   = s_tdata[23:16];
	assign in_range = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
	assign in_addr  = addr_of(LINE_W'(in_row), LINE_W'(in_col));
	assign accept   = s_tvalid && s_tready;

	// Sequencer.
	state_t            state_q;
	logic              second_q, zero_flag_q;
	logic [LINE_W-1:0] ln_q, pos_q;
	logic [4:0]        drain_q;
	logic [LINE_W-1:0] len, nlines, kclamp, wpos;
	logic              line_end;

	assign len      = second_q ? cols_eff : rows_eff;
	assign nlines   = second_q ? rows_eff : cols_eff;
	assign wpos     = pos_q - LINE_W'(8);
	assign line_end = state_q == ST_CLEAR ? (pos_q == cols_eff - LINE_W'(1))
	                                     : (pos_q == len + LINE_W'(7));

	always_comb begin
		if (pos_q < LINE_W'(CENTER)) kclamp = '0;
		else if (pos_q - LINE_W'(CENTER) >= len) kclamp = len - LINE_W'(1);
		else kclamp = pos_q - LINE_W'(CENTER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			second_q    <= 1'b0;
			zero_flag_q <= 1'b0;
			ln_q        <= '0;
			pos_q       <= '0;
			drain_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_kind == KIND_RUN) begin
						zero_flag_q <= (wsum == '0);
						second_q    <= 1'b0;
						ln_q        <= '0;
						pos_q       <= '0;
						state_q     <= (wsum == '0) ? ST_CLEAR : ST_PASS1;
					end
				end
				ST_PASS1, ST_PASS2, ST_CLEAR: begin
					if (line_end) begin
						pos_q <= '0;
						if (ln_q == (state_q == ST_CLEAR ? rows_eff : nlines) - LINE_W'(1))
						begin
							ln_q    <= '0;
							drain_q <= '0;
							state_q <= (state_q == ST_CLEAR) ? ST_IDLE : ST_DRAIN;
						end else begin
							ln_q <= ln_q + LINE_W'(1);
						end
					end else begin
						pos_q <= pos_q + LINE_W'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 5'd1;
					if (drain_q == '1) begin
						second_q <= 1'b1;
						state_q  <= second_q ? ST_IDLE : ST_PASS2;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Read result path.
	logic       rd_pend_q, rd_inside_q, rd_flag_q, out_free;
	logic       m_tvalid_q, m_tuser_q;
	logic [7:0] m_tdata_q;
	logic [7:0] frame_rd_s1;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && !(rd_pend_q && !out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (rd_pend_q && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (accept && in_kind == KIND_READ) rd_pend_q <= 1'b1;
			else if (out_free) rd_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_kind == KIND_READ) begin
			rd_inside_q <= in_range;
			rd_flag_q   <= zero_flag_q;
		end
		if (rd_pend_q && out_free) begin
			m_tdata_q <= rd_inside_q ? frame_rd_s1 : '0;
			m_tuser_q <= rd_flag_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Stores.
	logic [PIX_W-1:0]    frame_mem [DEPTH];
	logic [SAMPLE_W-1:0] pass_mem  [DEPTH];
	logic [SAMPLE_W-1:0] pass_rd_s1;
	logic [AW-1:0]       feed_addr, clear_addr;
	logic                frame_rd_en, host_wr, clear_wr, wb_frame, wb_pass;
	logic [AW-1:0]       frame_waddr;
	logic [PIX_W-1:0]    frame_wdata;
	logic                tag_valid_q [TAG_N];
	logic [AW-1:0]       tag_addr_q  [TAG_N];
	logic [QUOT_W-1:0]   quot [QUOT_W+1];

	assign feed_addr   = (state_q == ST_PASS1) ? addr_of(kclamp, ln_q) : addr_of(ln_q, kclamp);
	assign clear_addr  = addr_of(ln_q, pos_q);
	assign frame_rd_en = (accept && in_kind == KIND_READ) || state_q == ST_PASS1;
	assign host_wr     = accept && in_kind == KIND_WRITE && in_range;
	assign clear_wr    = state_q == ST_CLEAR;
	assign wb_frame    = tag_valid_q[TAG_N-1] && second_q;
	assign wb_pass     = tag_valid_q[TAG_N-1] && !second_q;

	always_comb begin
		priority if (host_wr) begin
			frame_waddr = in_addr;
			frame_wdata = in_pix;
		end else if (clear_wr) begin
			frame_waddr = clear_addr;
			frame_wdata = '0;
		end else begin
			frame_waddr = tag_addr_q[TAG_N-1];
			frame_wdata = quot[QUOT_W][PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (host_wr || clear_wr || wb_frame) frame_mem[frame_waddr] <= frame_wdata;
		if (frame_rd_en)
			frame_rd_s1 <= frame_mem[(state_q == ST_PASS1) ? feed_addr : in_addr];
		if (clear_wr) pass_mem[clear_addr] <= '0;
		else if (wb_pass) pass_mem[tag_addr_q[TAG_N-1]] <= quot[QUOT_W];
		if (state_q == ST_PASS2) pass_rd_s1 <= pass_mem[feed_addr];
	end

	// Tags follow each sample through the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAG_N; i++) tag_valid_q[i] <= 1'b0;
		end else begin
			tag_valid_q[0] <= (state_q == ST_PASS1 || state_q == ST_PASS2)
				&& pos_q >= LINE_W'(8);
			for (int i = 1; i < TAG_N; i++) tag_valid_q[i] <= tag_valid_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		tag_addr_q[0] <= (state_q == ST_PASS1) ? addr_of(wpos, ln_q) : addr_of(ln_q, wpos);
		for (int i = 1; i < TAG_N; i++) tag_addr_q[i] <= tag_addr_q[i-1];
	end

	// Tap line.
	logic [SAMPLE_W-1:0] sample [NTAPS+1];
	logic [PROD_W-1:0]   prod   [NTAPS];

	assign sample[0] = second_q ? pass_rd_s1 : SAMPLE_W'(frame_rd_s1);

	for (genvar j = 0; j < NTAPS; j++) begin : g_tap
		sgb_tap_cell u_cell (
			.clk      (clk),
			.sample_in(sample[j]),
			.weight   (weight[j]),
			.sample_q (sample[j+1]),
			.prod_q   (prod[j])
		);
	end

	// Adder tree and numerator.
	logic [PROD_W:0]    psum_s4 [5];
	logic [TOTAL_W-1:0] total_s5;
	logic [REM_W-1:0]   num_s6;
	logic [DIVISOR_W-1:0] divisor;

	assign divisor = second_q ? {wsum, 8'd0} : DIVISOR_W'({wsum, 1'b0});

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++)
			psum_s4[i] <= (PROD_W+1)'(prod[2*i]) + (PROD_W+1)'(prod[2*i+1]);
		psum_s4[4] <= (PROD_W+1)'(prod[NTAPS-1]);
		total_s5 <= TOTAL_W'(psum_s4[0]) + TOTAL_W'(psum_s4[1]) + TOTAL_W'(psum_s4[2])
		          + TOTAL_W'(psum_s4[3]) + TOTAL_W'(psum_s4[4]);
		if (second_q) num_s6 <= REM_W'(total_s5) + (REM_W'(wsum) << 7);
		else num_s6 <= (REM_W'(total_s5) << 9) + REM_W'(wsum);
	end

	// Divider line, most significant quotient bit first.
	logic [REM_W-1:0] rem [QUOT_W+1];

	assign rem[0]  = num_s6;
	assign quot[0] = '0;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		sgb_div_cell #(.SHIFT(QUOT_W - 1 - k)) u_cell (
			.clk    (clk),
			.rem_in (rem[k]),
			.quot_in(quot[k]),
			.divisor(divisor),
			.rem_q  (rem[k+1]),
			.quot_q (quot[k+1])
		);
	end

	// Checks.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({host_wr, clear_wr, wb_frame}))
		else $error("frame store written by two sources");
	a_wb_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid_q[TAG_N-1] |-> (state_q == ST_PASS1 || state_q == ST_PASS2
		|| state_q == ST_DRAIN))
		else $error("writeback outside a run");
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q && !out_free |=> rd_pend_q && $stable(frame_rd_s1))
		else $error("pending read lost");
	a_clear_flag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> zero_flag_q)
		else $error("clear sweep without zero tap sum");

endmodule

@@ test/separable_gaussian_blur_tb.sv @@
// Self-checking testbench for separable_gaussian_blur: pixel writes, reads, blur runs and
// kind-3 noise on the stream ports, with random idling and stalls on both sides.
// Depends on sgb_pkg and the RTL of the block only.
module separable_gaussian_blur_tb;
	import sgb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	class blur_scoreboard;
		typedef struct {
			bit [7:0] value;
			bit       zero_weight;
		} read_result_t;

		bit [7:0]     frame_mem[65536];
		bit [15:0]    pass_mem[65536];
		bit           zero_flag;
		bit [8:0]     rows_reg;
		bit [8:0]     cols_reg;
		bit [2:0]     half_reg;
		bit [15:0]    tap[5];
		read_result_t awaited[$];
		int           errors;

		function new();
			rows_reg = 256;
			cols_reg = 256;
			half_reg = 4;
			tap = '{26145, 15857, 3539, 290, 9};
		endfunction

		function int eff_dim(bit [8:0] v);
			if (v == 0) begin
				return 1;
			end
			return (v > 256) ? 256 : int'(v);
		endfunction

		function int clamp_idx(int v, int n);
			if (v < 0) begin
				return 0;
			end
			return (v > n - 1) ? n - 1 : v;
		endfunction

		function void set_reg(cfg_reg_t idx, bit [15:0] d);
			case (idx)
				REG_ROWS: rows_reg = d[8:0];
				REG_COLS: cols_reg = d[8:0];
				REG_HALF: half_reg = d[2:0];
				REG_TAP0: tap[0] = d;
				REG_TAP1: tap[1] = d;
				REG_TAP2: tap[2] = d;
				REG_TAP3: tap[3] = d;
				REG_TAP4: tap[4] = d;
			endcase
		endfunction

		function void blur();
			int rows, cols, hw, s, k;
			longint unsigned wsum, acc, w;
			rows = eff_dim(rows_reg);
			cols = eff_dim(cols_reg);
			hw = (half_reg > 4) ? 4 : int'(half_reg);
			wsum = tap[0];
			for (s = 1; s <= hw; s++) begin
				wsum += 2 * longint'(tap[s]);
			end
			if (wsum == 0) begin
				zero_flag = 1;
				for (int r = 0; r < rows; r++) begin
					for (int c = 0; c < cols; c++) begin
						frame_mem[r * 256 + c] = 0;
						pass_mem[r * 256 + c] = 0;
					end
				end
				return;
			end
			zero_flag = 0;
			// Vertical pass into the Q8.8 intermediate, rounded half up.
			for (int c = 0; c < cols; c++) begin
				for (int r = 0; r < rows; r++) begin
					acc = 0;
					for (s = -hw; s <= hw; s++) begin
						k = (s < 0) ? -s : s;
						w = tap[k];
						acc += w * frame_mem[clamp_idx(r + s, rows) * 256 + c];
					end
					pass_mem[r * 256 + c] = 16'((512 * acc + wsum) / (2 * wsum));
				end
			end
			for (int c = 0; c < cols; c++) begin
				for (int r = 0; r < rows; r++) begin
					acc = 0;
					for (s = -hw; s <= hw; s++) begin
						k = (s < 0) ? -s : s;
						w = tap[k];
						acc += w * pass_mem[r * 256 + clamp_idx(c + s, cols)];
					end
					frame_mem[r * 256 + c] = 8'((acc + 128 * wsum) / (256 * wsum));
				end
			end
		endfunction

		function void note_request(kind_t k, bit [7:0] r, bit [7:0] c, bit [7:0] p);
			read_result_t res;
			case (k)
				KIND_WRITE: frame_mem[r * 256 + c] = p;
				KIND_RUN: blur();
				KIND_READ: begin
					res.value = frame_mem[r * 256 + c];
					res.zero_weight = zero_flag;
					awaited.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void check_result(bit [7:0] value, bit zero_weight);
			read_result_t res;
			if (awaited.size() == 0) begin
				$error("read result %0d arrived with no read request pending", value);
				errors++;
				return;
			end
			res = awaited.pop_front();
			if (value !== res.value) begin
				$error("value: expected %0d, got %0d", res.value, value);
				errors++;
			end
			if (zero_weight !== res.zero_weight) begin
				$error("zero_weight: expected %0d, got %0d", res.zero_weight, zero_weight);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;   // row, col, pixel
	logic [1:0]           s_tuser = KIND_NONE;   // kind
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [7:0]           m_tdata;   // value
	logic                 m_tuser;   // zero_weight
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_ROWS;
	logic [CFG_W-1:0]     cfg_data = '0;

	blur_scoreboard sb = new();
	bit             s_fire = 0;
	int             send_pct = 14;
	int             recv_pct = 65;
	bit             hold_req = 0;
	int             hold_left = 0;
	int             quiet_cycles = 0;
	bit             written[65536];
	int             written_list[$];
	int             sent_items = 0;

	separable_gaussian_blur dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_request(kind_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
		end
		if (arst_n && cfg_we) begin
			sb.set_reg(cfg_reg_t'(cfg_idx), cfg_data);
		end
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tuser);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// The receiver holds off for a long stretch whenever the sender asks for it.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_pct);
		end
	end

	task automatic send_item(kind_t k, bit [7:0] r, bit [7:0] c, bit [7:0] p);
		if (sent_items < 170) begin
			send_pct = 14;
			recv_pct = 65;
		end else if (sent_items < 340) begin
			send_pct = 65;
			recv_pct = 14;
		end else begin
			send_pct = 0;
			recv_pct = 0;
		end
		if (s_tvalid && $urandom_range(99) < send_pct) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= k;
		s_tdata <= {p, c, r};
		do @(negedge clk); while (!s_fire);
		sent_items++;
	endtask

	task automatic stop_sending();
		s_tvalid <= 0;
		@(negedge clk);
	endtask

	task automatic wait_results();
		while (sb.awaited.size() != 0) @(negedge clk);
	endtask

	task automatic write_pixel(bit [7:0] r, bit [7:0] c, bit [7:0] p);
		send_item(KIND_WRITE, r, c, p);
		if (!written[r * 256 + c]) begin
			written[r * 256 + c] = 1;
			written_list.push_back(r * 256 + c);
		end
	endtask

	task automatic read_known();
		int a;
		a = written_list[$urandom_range(written_list.size() - 1)];
		send_item(KIND_READ, 8'(a / 256), 8'(a % 256), 8'($urandom));
	endtask

	task automatic run_phase(bit [8:0] rows, bit [8:0] cols, bit [2:0] hw, bit [15:0] t0,
			bit [15:0] t1, bit [15:0] t2, bit [15:0] t3, bit [15:0] t4, int n, bit squeeze);
		bit [15:0] vals[8];
		int nr, nc, pick, settle;
		vals = '{rows, cols, hw, t0, t1, t2, t3, t4};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1;
			cfg_idx <= cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 0;
		@(negedge clk);
		nr = sb.eff_dim(rows);
		nc = sb.eff_dim(cols);
		// Every pixel of the active frame is loaded before any run.
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				write_pixel(8'(r), 8'(c), 8'($urandom));
			end
		end
		send_item(KIND_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
		if (squeeze) begin
			// The first read is accepted only once the run is over.
			read_known();
			hold_req = 1;
			repeat (39) read_known();
			stop_sending();
			wait_results();
		end
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				send_item(KIND_READ, 8'($urandom_range(nr - 1)), 8'($urandom_range(nc - 1)),
					8'($urandom));
			end else if (pick < 40) begin
				read_known();
			end else if (pick < 60) begin
				write_pixel(8'($urandom_range(nr - 1)), 8'($urandom_range(nc - 1)),
					8'($urandom));
			end else if (pick < 72) begin
				write_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			end else if (pick < 92) begin
				send_item(KIND_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				send_item(KIND_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
			end
			if (squeeze && i == n / 2) begin
				stop_sending();
				wait_results();
			end
		end
		stop_sending();
		wait_results();
		// A run after the last read may still be busy.
		settle = 2 * nr * nc + 10 * (nr + nc) + 100;
		repeat (settle) @(negedge clk);
	endtask

	function automatic bit [15:0] random_tap(int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 400));
			default: return ($urandom_range(3) == 0) ? 16'hFFFF : 16'h0;
		endcase
	endfunction

	initial begin
		int style, n;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Extremes of the coordinates and pixel, unused kind, read after write.
		write_pixel(0, 0, 8'h00);
		write_pixel(255, 255, 8'hFF);
		write_pixel(0, 255, 8'hAA);
		write_pixel(255, 0, 8'h55);
		send_item(KIND_READ, 0, 0, 0);
		send_item(KIND_READ, 255, 255, 0);
		send_item(KIND_NONE, 8'hFF, 8'hFF, 8'hFF);
		send_item(KIND_READ, 0, 255, 8'hFF);
		write_pixel(255, 0, 8'hC3);
		send_item(KIND_READ, 255, 0, 0);
		stop_sending();
		wait_results();

		run_phase(1, 1, 0, 16'hFFFF, 0, 0, 0, 0, 6, 0);
		run_phase(0, 0, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6, 0);
		run_phase(511, 1, 4, 26145, 15857, 3539, 290, 9, 10, 1);
		run_phase(2, 9, 2, 1, 16'hFFFF, 16'h8000, 3, 4, 10, 0);
		run_phase(5, 7, 3, 0, 0, 0, 0, 0, 15, 0);
		run_phase(3, 4, 1, 0, 16'h7FFF, 0, 0, 0, 15, 0);

		while (sent_items < 500) begin
			style = $urandom_range(2);
			n = $urandom_range(10, 20);
			run_phase(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
				3'($urandom_range(0, 7)),
				random_tap(style), random_tap(style), random_tap(style),
				random_tap(style), random_tap(style), n, 0);
		end

		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/sgb_pkg.sv
rtl/core/sgb_tap_cell.sv
rtl/core/sgb_div_cell.sv
rtl/core/separable_gaussian_blur.sv
test/separable_gaussian_blur_tb.sv
